### hw/rtl/bld_pkg.sv
package bld_pkg;

   localparam int SECTOR_W      = 64;
   localparam int OFFSET_W      = 30;
   localparam int CSR_INDEX_W   = 2;
   localparam int CSR_DATA_W    = 16;

   localparam int WIDTH_GOBS_W  = 11;
   localparam int BLOCK_GOBS_W  = 6;
   localparam int LINES_W       = 15;

   localparam int GOB_BYTES_LOG2 = 6;
   localparam int GOB_LINES_LOG2 = 3;
   localparam int SECTOR_IDX_W   = 5;
   localparam int GOB_IDX_W      = 5;
   localparam int MAX_BLOCK_GOBS = 32;
   localparam int QUEUE_DEPTH    = 2;

   localparam int MAX_WIDTH_GOBS_DEFAULT = 1024;
   localparam int MAX_LINES_DEFAULT      = 16384;

   localparam logic [CSR_INDEX_W-1:0] CSR_WIDTH_GOBS    = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_BLOCK_HEIGHT  = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_SURFACE_LINES = 2'd2;

   localparam logic [WIDTH_GOBS_W-1:0] WIDTH_GOBS_RESET    = 11'd1;
   localparam logic [BLOCK_GOBS_W-1:0] BLOCK_GOBS_RESET    = 6'd16;
   localparam logic [LINES_W-1:0]      SURFACE_LINES_RESET = 15'd1;

   typedef struct packed {
      logic [WIDTH_GOBS_W-1:0] width_gobs;
      logic [BLOCK_GOBS_W-1:0] block_height_gobs;
      logic [LINES_W-1:0]      surface_lines;
   } cfg_type;

endpackage

### hw/rtl/bld_req_if.sv
interface bld_req_if;
   logic                          valid;
   logic                          ready;
   logic [bld_pkg::SECTOR_W-1:0]  sector_low;
   logic [bld_pkg::SECTOR_W-1:0]  sector_high;

   modport source (output valid, output sector_low, output sector_high, input ready);
   modport sink   (input valid, input sector_low, input sector_high, output ready);
endinterface

### hw/rtl/bld_rsp_if.sv
interface bld_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [bld_pkg::OFFSET_W-1:0]  dest_offset;
   logic [bld_pkg::SECTOR_W-1:0]  out_low;
   logic [bld_pkg::SECTOR_W-1:0]  out_high;
   logic                          last;

   modport source (output valid, output dest_offset, output out_low, output out_high,
                   output last, input ready);
   modport sink   (input valid, input dest_offset, input out_low, input out_high,
                   input last, output ready);
endinterface

### hw/rtl/bld_csr_if.sv
interface bld_csr_if;
   logic                            valid;
   logic                            ready;
   logic [bld_pkg::CSR_INDEX_W-1:0] index;
   logic [bld_pkg::CSR_DATA_W-1:0]  data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

### hw/rtl/bld_front.sv
module bld_front #(
   parameter int LINE_W = 15,
   parameter int BA_W   = 10
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          restart,
   input  bld_pkg::cfg_type              cfg,
   bld_req_if.sink                       req_ch,
   output logic                          push_valid,
   input  logic                          push_ready,
   output logic [2*bld_pkg::SECTOR_W+1+LINE_W+BA_W+bld_pkg::GOB_BYTES_LOG2-1:0] push_data
);

   localparam int COL_W  = BA_W + bld_pkg::GOB_BYTES_LOG2;
   localparam int LCMP_W = (LINE_W > bld_pkg::LINES_W ? LINE_W : bld_pkg::LINES_W) + 1;
   localparam int BCMP_W = (BA_W > bld_pkg::WIDTH_GOBS_W ? BA_W : bld_pkg::WIDTH_GOBS_W) + 1;
   localparam int GCMP_W = bld_pkg::BLOCK_GOBS_W + 1;

   typedef struct packed {
      logic [bld_pkg::SECTOR_W-1:0] high;
      logic [bld_pkg::SECTOR_W-1:0] low;
      logic                         fin;
      logic [LINE_W-1:0]            line;
      logic [COL_W-1:0]             col;
   } entry_type;

   logic [bld_pkg::SECTOR_IDX_W-1:0] sector_ff, sector_in;
   logic [bld_pkg::GOB_IDX_W-1:0]    gob_ff, gob_in;
   logic [BA_W-1:0]                  ba_ff, ba_in;
   logic [LINE_W-1:0]                row_base_ff, row_base_in;

   logic [2:0]        yt;
   logic [LINE_W-1:0] line;
   logic [LCMP_W-1:0] line_x;
   logic [LCMP_W-1:0] sl_x;
   logic [LCMP_W-1:0] row_next;
   logic [LINE_W-1:0] rob_lines;
   logic              keep;
   logic              right_edge;
   logic              gob_end;
   logic              accept;
   entry_type         entry;

   assign yt        = {sector_ff[3], sector_ff[2], sector_ff[0]};
   assign line      = row_base_ff + LINE_W'({gob_ff, yt});
   assign line_x    = LCMP_W'(line);
   assign sl_x      = LCMP_W'(cfg.surface_lines);
   assign keep      = line_x < sl_x;
   assign rob_lines = LINE_W'({cfg.block_height_gobs, 3'b000});
   assign row_next  = LCMP_W'(row_base_ff) + LCMP_W'(rob_lines);
   assign right_edge = (BCMP_W'(ba_ff) + BCMP_W'(1)) >= BCMP_W'(cfg.width_gobs);
   assign gob_end    = (GCMP_W'(gob_ff) + GCMP_W'(1)) >= GCMP_W'(cfg.block_height_gobs);

   assign req_ch.ready = push_ready || !keep;
   assign accept       = req_ch.valid && req_ch.ready;
   assign push_valid   = req_ch.valid && keep;

   always_comb begin
      entry.high = req_ch.sector_high;
      entry.low  = req_ch.sector_low;
      entry.line = line;
      entry.col  = {ba_ff, sector_ff[4], sector_ff[1], 4'b0000};
      entry.fin  = (line_x + LCMP_W'(1) == sl_x) && right_edge && sector_ff[4] && sector_ff[1];
   end
   assign push_data = entry;

   always_comb begin
      sector_in   = sector_ff;
      gob_in      = gob_ff;
      ba_in       = ba_ff;
      row_base_in = row_base_ff;
      if (restart) begin
         sector_in   = '0;
         gob_in      = '0;
         ba_in       = '0;
         row_base_in = '0;
      end else if (accept) begin
         sector_in = sector_ff + 1'b1;
         if (&sector_ff) begin
            if (gob_end) begin
               gob_in = '0;
               if (right_edge) begin
                  ba_in = '0;
                  if (row_next >= sl_x) begin
                     row_base_in = '0;
                  end else begin
                     row_base_in = row_next[LINE_W-1:0];
                  end
               end else begin
                  ba_in = ba_ff + 1'b1;
               end
            end else begin
               gob_in = gob_ff + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sector_ff   <= '0;
         gob_ff      <= '0;
         ba_ff       <= '0;
         row_base_ff <= '0;
      end else begin
         sector_ff   <= sector_in;
         gob_ff      <= gob_in;
         ba_ff       <= ba_in;
         row_base_ff <= row_base_in;
      end
   end

   a_gob_in_block : assert property (@(posedge clock) disable iff (reset)
      GCMP_W'(gob_ff) < GCMP_W'(cfg.block_height_gobs))
      else $error("GOB index past block height");

   a_block_in_row : assert property (@(posedge clock) disable iff (reset)
      BCMP_W'(ba_ff) < BCMP_W'(cfg.width_gobs))
      else $error("block index past surface width");

   a_row_in_surface : assert property (@(posedge clock) disable iff (reset)
      LCMP_W'(row_base_ff) < sl_x)
      else $error("row of blocks starts past surface");

endmodule

### hw/rtl/bld_queue.sv
module bld_queue #(
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  logic [WIDTH-1:0] push_data,
   output logic             pop_valid,
   input  logic             pop_ready,
   output logic [WIDTH-1:0] pop_data
);

   localparam int DEPTH = bld_pkg::QUEUE_DEPTH;
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             push_fire;
   logic             pop_fire;

   assign push_ready = count_ff != CNT_W'(DEPTH);
   assign pop_valid  = count_ff != '0;
   assign pop_data   = mem_ff[rd_ptr_ff];
   assign push_fire  = push_valid && push_ready;
   assign pop_fire   = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push_fire) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop_fire) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push_fire && !pop_fire) begin
         count_in = count_ff + 1'b1;
      end else if (pop_fire && !push_fire) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_fire) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      32'(count_ff) <= DEPTH)
      else $error("queue holds more entries than its depth");

   a_count_track : assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> 32'(count_ff) ==
         32'($past(count_ff)) + 32'($past(push_fire)) - 32'($past(pop_fire)))
      else $error("queue count lost track of transfers");

endmodule

### hw/rtl/bld_back.sv
module bld_back #(
   parameter int LINE_W = 15,
   parameter int BA_W   = 10
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic [bld_pkg::WIDTH_GOBS_W-1:0]     width_gobs,
   input  logic                                 pop_valid,
   output logic                                 pop_ready,
   input  logic [2*bld_pkg::SECTOR_W+1+LINE_W+BA_W+bld_pkg::GOB_BYTES_LOG2-1:0] pop_data,
   bld_rsp_if.source                            rsp_ch
);

   localparam int COL_W  = BA_W + bld_pkg::GOB_BYTES_LOG2;
   localparam int PROD_W = LINE_W + bld_pkg::WIDTH_GOBS_W;
   localparam int SUM_W  = PROD_W + bld_pkg::GOB_BYTES_LOG2 + 1;
   localparam int OFF_W  = (SUM_W > bld_pkg::OFFSET_W) ? SUM_W : bld_pkg::OFFSET_W;

   typedef struct packed {
      logic [bld_pkg::SECTOR_W-1:0] high;
      logic [bld_pkg::SECTOR_W-1:0] low;
      logic                         fin;
      logic [LINE_W-1:0]            line;
      logic [COL_W-1:0]             col;
   } entry_type;

   entry_type                    entry;
   logic [PROD_W-1:0]            prod;
   logic [OFF_W-1:0]             sum;
   logic                         pop_fire;

   logic                         rsp_valid_ff, rsp_valid_in;
   logic [bld_pkg::OFFSET_W-1:0] dest_offset_ff;
   logic [bld_pkg::SECTOR_W-1:0] low_ff;
   logic [bld_pkg::SECTOR_W-1:0] high_ff;
   logic                         last_ff;

   assign entry     = pop_data;
   assign prod      = PROD_W'(entry.line) * PROD_W'(width_gobs);
   assign sum       = OFF_W'({prod, {bld_pkg::GOB_BYTES_LOG2{1'b0}}}) + OFF_W'(entry.col);
   assign pop_ready = !rsp_valid_ff || rsp_ch.ready;
   assign pop_fire  = pop_valid && pop_ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (pop_fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop_fire) begin
         dest_offset_ff <= sum[bld_pkg::OFFSET_W-1:0];
         low_ff         <= entry.low;
         high_ff        <= entry.high;
         last_ff        <= entry.fin;
      end
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.dest_offset = dest_offset_ff;
   assign rsp_ch.out_low     = low_ff;
   assign rsp_ch.out_high    = high_ff;
   assign rsp_ch.last        = last_ff;

endmodule

### hw/rtl/block_linear_deswizzle.sv
// Path: a sector accepted on req is written into the queue, then into the output register,
// from which it is offered on rsp; a full queue or a stalled rsp holds it on the way.
// Throughput: one sector per cycle while rsp is ready; the walk counters advance once per transfer and
// the two-entry queue plus the output register keep both sides moving.
// Padding sectors and lines past the surface are accepted with no result, even while the queue is full.
// Reset (synchronous): walk restarts at the first sector, registers return to
// width 1 GOB, block height 16 GOBs, 1 line; there is no clearing pass.
module block_linear_deswizzle #(
   parameter int MAX_WIDTH_GOBS = bld_pkg::MAX_WIDTH_GOBS_DEFAULT,
   parameter int MAX_LINES      = bld_pkg::MAX_LINES_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   bld_req_if.sink    req_ch,
   bld_rsp_if.source  rsp_ch,
   bld_csr_if.sink    csr_ch
);

   localparam int LINE_W  = $clog2(MAX_LINES + 2 * bld_pkg::MAX_BLOCK_GOBS * 8);
   localparam int BA_W    = (MAX_WIDTH_GOBS > 1) ? $clog2(MAX_WIDTH_GOBS) : 1;
   localparam int ENTRY_W = 2 * bld_pkg::SECTOR_W + 1 + LINE_W + BA_W
                            + bld_pkg::GOB_BYTES_LOG2;

   bld_pkg::cfg_type cfg_ff, cfg_in;
   logic             restart;

   logic               push_valid;
   logic               push_ready;
   logic [ENTRY_W-1:0] push_data;
   logic               pop_valid;
   logic               pop_ready;
   logic [ENTRY_W-1:0] pop_data;

   assign csr_ch.ready = 1'b1;

   always_comb begin
      logic [bld_pkg::WIDTH_GOBS_W-1:0] v_w;
      logic [bld_pkg::BLOCK_GOBS_W-1:0] v_b;
      logic [bld_pkg::LINES_W-1:0]      v_l;
      v_w     = csr_ch.data[bld_pkg::WIDTH_GOBS_W-1:0];
      v_b     = csr_ch.data[bld_pkg::BLOCK_GOBS_W-1:0];
      v_l     = csr_ch.data[bld_pkg::LINES_W-1:0];
      cfg_in  = cfg_ff;
      restart = 1'b0;
      if (csr_ch.valid && csr_ch.ready) begin
         unique case (csr_ch.index)
            bld_pkg::CSR_WIDTH_GOBS: begin
               restart = 1'b1;
               if (v_w == '0) begin
                  cfg_in.width_gobs = bld_pkg::WIDTH_GOBS_W'(1);
               end else if (32'(v_w) > MAX_WIDTH_GOBS) begin
                  cfg_in.width_gobs = bld_pkg::WIDTH_GOBS_W'(MAX_WIDTH_GOBS);
               end else begin
                  cfg_in.width_gobs = v_w;
               end
            end
            bld_pkg::CSR_BLOCK_HEIGHT: begin
               restart = 1'b1;
               if (v_b == '0) begin
                  cfg_in.block_height_gobs = bld_pkg::BLOCK_GOBS_W'(1);
               end else if (32'(v_b) > bld_pkg::MAX_BLOCK_GOBS) begin
                  cfg_in.block_height_gobs = bld_pkg::BLOCK_GOBS_W'(bld_pkg::MAX_BLOCK_GOBS);
               end else begin
                  cfg_in.block_height_gobs = v_b;
               end
            end
            bld_pkg::CSR_SURFACE_LINES: begin
               restart = 1'b1;
               if (v_l == '0) begin
                  cfg_in.surface_lines = bld_pkg::LINES_W'(1);
               end else if (32'(v_l) > MAX_LINES) begin
                  cfg_in.surface_lines = bld_pkg::LINES_W'(MAX_LINES);
               end else begin
                  cfg_in.surface_lines = v_l;
               end
            end
            default: begin
               restart = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.width_gobs        <= bld_pkg::WIDTH_GOBS_RESET;
         cfg_ff.block_height_gobs <= bld_pkg::BLOCK_GOBS_RESET;
         cfg_ff.surface_lines     <= bld_pkg::SURFACE_LINES_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   bld_front #(
      .LINE_W (LINE_W),
      .BA_W   (BA_W)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .restart    (restart),
      .cfg        (cfg_ff),
      .req_ch     (req_ch),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data)
   );

   bld_queue #(
      .WIDTH (ENTRY_W)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   bld_back #(
      .LINE_W (LINE_W),
      .BA_W   (BA_W)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .width_gobs (cfg_ff.width_gobs),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data),
      .rsp_ch     (rsp_ch)
   );

endmodule
